// ----- hdl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the checker file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLY(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
		else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
		else $error("assertion failed");

`endif

// ----- hdl/mntps_pkg.sv -----
// ----------------------------------------------------------------------------
// mntps_pkg
// Shared types and constants of the mesh neighbor table and parent select.
// ----------------------------------------------------------------------------
`default_nettype none

package mntps_pkg;

	typedef enum logic [1:0] {
		ACT_HELLO = 2'd0,
		ACT_TICK  = 2'd1,
		ACT_BEAT  = 2'd2,
		ACT_ACK   = 2'd3
	} action_t;

	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] CFG_GATEWAY   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MY_ADDR   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_RETRY_LIM = 3'd4;

	localparam logic [7:0]        HOP_UNSYNC = 8'hFF;
	localparam logic signed [7:0] RSSI_FLOOR = -8'sd128;

	typedef enum logic [4:0] {
		OP_NONE,
		OP_LOAD,
		OP_IDX_INC,
		OP_FOUND,
		OP_CREATE,
		OP_HELLO_DROP,
		OP_SAMPLE,
		OP_SUM_ACC,
		OP_DIV_START,
		OP_DIV_STEP,
		OP_HELLO_WRITE,
		OP_KEEP,
		OP_COPY,
		OP_ADVANCE,
		OP_TICK_FINAL,
		OP_BEAT,
		OP_ACK,
		OP_EMIT
	} dp_op_t;

	typedef struct packed {
		action_t action;
		logic    self_hello;
		logic    idx_end;
		logic    match;
		logic    table_full;
		logic    stale;
		logic    keep_differs;
		logic    copy_last;
		logic    sum_last;
		logic    div_last;
		logic    out_free;
	} dp_status_t;

endpackage

`default_nettype wire

// ----- hdl/mntps_ctrl.sv -----
// ----------------------------------------------------------------------------
// mntps_ctrl
// Sequencer: walks the table for hello and process tick items and issues datapath operations.
// ----------------------------------------------------------------------------
`default_nettype none

module mntps_ctrl import mntps_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  dp_status_t      status,
	output dp_op_t          op
);

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_H_WAIT,
		ST_H_CHK,
		ST_H_SAMPLE,
		ST_S_WAIT,
		ST_S_ACC,
		ST_D_START,
		ST_D_RUN,
		ST_H_WRITE,
		ST_P_WAIT,
		ST_P_CHK,
		ST_P_COPY_WAIT,
		ST_P_COPY,
		ST_P_ADV,
		ST_P_FINAL,
		ST_BEAT,
		ST_ACK,
		ST_EMIT
	} state_t;

	state_t state_q;
	state_t state_d;

	assign in_stall = (state_q != ST_IDLE);

	always_comb begin
		state_d = state_q;
		op      = OP_NONE;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					op      = OP_LOAD;
					state_d = ST_DISPATCH;
				end
			end
			ST_DISPATCH: begin
				unique case (status.action)
					ACT_HELLO: state_d = status.self_hello ? ST_EMIT : ST_H_WAIT;
					ACT_TICK:  state_d = ST_P_WAIT;
					ACT_BEAT:  state_d = ST_BEAT;
					ACT_ACK:   state_d = ST_ACK;
					default:   state_d = ST_EMIT;
				endcase
			end
			ST_H_WAIT: begin
				if (!status.idx_end) begin
					state_d = ST_H_CHK;
				end else if (status.table_full) begin
					op      = OP_HELLO_DROP;
					state_d = ST_EMIT;
				end else begin
					op      = OP_CREATE;
					state_d = ST_H_SAMPLE;
				end
			end
			ST_H_CHK: begin
				if (status.match) begin
					op      = OP_FOUND;
					state_d = ST_H_SAMPLE;
				end else begin
					op      = OP_IDX_INC;
					state_d = ST_H_WAIT;
				end
			end
			ST_H_SAMPLE: begin
				op      = OP_SAMPLE;
				state_d = ST_S_WAIT;
			end
			ST_S_WAIT: state_d = ST_S_ACC;
			ST_S_ACC: begin
				op      = OP_SUM_ACC;
				state_d = status.sum_last ? ST_D_START : ST_S_WAIT;
			end
			ST_D_START: begin
				op      = OP_DIV_START;
				state_d = ST_D_RUN;
			end
			ST_D_RUN: begin
				op      = OP_DIV_STEP;
				if (status.div_last) begin
					state_d = ST_H_WRITE;
				end
			end
			ST_H_WRITE: begin
				op      = OP_HELLO_WRITE;
				state_d = ST_EMIT;
			end
			ST_P_WAIT: state_d = status.idx_end ? ST_P_FINAL : ST_P_CHK;
			ST_P_CHK: begin
				if (status.stale) begin
					op      = OP_IDX_INC;
					state_d = ST_P_WAIT;
				end else begin
					op      = OP_KEEP;
					state_d = status.keep_differs ? ST_P_COPY_WAIT : ST_P_ADV;
				end
			end
			ST_P_COPY_WAIT: state_d = ST_P_COPY;
			ST_P_COPY: begin
				op      = OP_COPY;
				state_d = status.copy_last ? ST_P_ADV : ST_P_COPY_WAIT;
			end
			ST_P_ADV: begin
				op      = OP_ADVANCE;
				state_d = ST_P_WAIT;
			end
			ST_P_FINAL: begin
				op      = OP_TICK_FINAL;
				state_d = ST_EMIT;
			end
			ST_BEAT: begin
				op      = OP_BEAT;
				state_d = ST_EMIT;
			end
			ST_ACK: begin
				op      = OP_ACK;
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (status.out_free) begin
					op      = OP_EMIT;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

// ----- hdl/mntps_datapath.sv -----
// ----------------------------------------------------------------------------
// mntps_datapath
// Neighbor table memories, RSSI windows, serial divider, parent state and
// result register.
// ----------------------------------------------------------------------------
`default_nettype none

module mntps_datapath import mntps_pkg::*; #(
	parameter int MAX_NEIGHBORS = 16,
	parameter int RSSI_WINDOW   = 8,
	localparam int CW = $clog2(MAX_NEIGHBORS + 1)
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  dp_op_t                    op,
	output dp_status_t                status,
	input  wire logic                 cfg_write,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [47:0]          cfg_data,
	input  wire logic [1:0]           action,
	input  wire logic [31:0]          now_ms,
	input  wire logic [47:0]          sender_address,
	input  wire logic [7:0]           sender_hop,
	input  wire logic                 sender_relay,
	input  wire logic signed [7:0]    link_rssi,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output logic                      parent_valid,
	output logic [47:0]               parent_address,
	output logic [7:0]                own_hop,
	output logic [CW-1:0]             neighbor_total,
	output logic                      parent_selected,
	output logic                      parent_dropped,
	output logic                      heartbeat_send,
	output logic [31:0]               heartbeat_number,
	output logic                      hello_dropped
);

	localparam int EW   = (MAX_NEIGHBORS > 1) ? $clog2(MAX_NEIGHBORS) : 1;
	localparam int SW   = (RSSI_WINDOW > 1) ? $clog2(RSSI_WINDOW) : 1;
	localparam int NW   = $clog2(RSSI_WINDOW + 1);
	localparam int SUMW = 8 + NW;
	localparam int DCW  = $clog2(SUMW + 1);
	localparam int WIN_DEPTH = 2 ** (EW + SW);

	// Item fields.
	action_t            act_q;
	logic [31:0]        now_q;
	logic [47:0]        addr_q;
	logic [7:0]         hop_in_q;
	logic               relay_in_q;
	logic signed [7:0]  rssi_q;

	// Configuration.
	logic        gw_q;
	logic [47:0] my_addr_q;
	logic [31:0] timeout_q;
	logic [31:0] interval_q;
	logic [7:0]  limit_q;

	// Node state.
	logic [CW-1:0] fill_q;
	logic [47:0]   par_addr_q;
	logic          par_ok_q;
	logic [7:0]    hop_q;
	logic [7:0]    unacked_q;
	logic [31:0]   last_beat_q;
	logic [31:0]   seq_q;

	// Walk counters and working values.
	logic [CW-1:0]         idx_q;
	logic [CW-1:0]         keep_q;
	logic [SW-1:0]         slot_q;
	logic [NW-1:0]         cur_cnt_q;
	logic [SW-1:0]         cur_wpos_q;
	logic signed [SUMW-1:0] sum_q;
	logic [NW-1:0]         rem_q;
	logic [SUMW-1:0]       quo_q;
	logic                  neg_q;
	logic [DCW-1:0]        div_cnt_q;

	// Leading parent candidate of the current tick.
	logic              found_q;
	logic [7:0]        lead_hop_q;
	logic              lead_relay_q;
	logic signed [7:0] lead_rssi_q;
	logic [47:0]       lead_addr_q;
	logic              present_q;

	// Item result flags.
	logic        sel_q;
	logic        drop_q;
	logic        hbs_q;
	logic [31:0] hbn_q;
	logic        hdrop_q;

	// Neighbor record memory, one field per array, shared address.
	logic [47:0]       rec_addr_m  [MAX_NEIGHBORS];
	logic [7:0]        rec_hop_m   [MAX_NEIGHBORS];
	logic              rec_relay_m [MAX_NEIGHBORS];
	logic [NW-1:0]     rec_cnt_m   [MAX_NEIGHBORS];
	logic [SW-1:0]     rec_wpos_m  [MAX_NEIGHBORS];
	logic signed [7:0] rec_avg_m   [MAX_NEIGHBORS];
	logic [31:0]       rec_seen_m  [MAX_NEIGHBORS];

	logic [47:0]       rd_addr_q;
	logic [7:0]        rd_hop_q;
	logic              rd_relay_q;
	logic [NW-1:0]     rd_cnt_q;
	logic [SW-1:0]     rd_wpos_q;
	logic signed [7:0] rd_avg_q;
	logic [31:0]       rd_seen_q;

	logic signed [7:0] win_m [WIN_DEPTH];
	logic signed [7:0] win_rd_q;

	logic              rec_we;
	logic [EW-1:0]     rec_wa;
	logic [47:0]       rec_w_addr;
	logic [7:0]        rec_w_hop;
	logic              rec_w_relay;
	logic [NW-1:0]     rec_w_cnt;
	logic [SW-1:0]     rec_w_wpos;
	logic signed [7:0] rec_w_avg;
	logic [31:0]       rec_w_seen;

	logic              win_we;
	logic [EW+SW-1:0]  win_wa;
	logic signed [7:0] win_wd;

	logic [SUMW-1:0]   quo_neg;
	logic signed [7:0] avg_w;
	logic [NW:0]       trial;
	logic [NW:0]       divisor;
	logic              eligible;
	logic              take;
	logic              ok1;
	logic              drop1;
	logic              drop2;
	logic              ok2;
	logic              pick;
	logic              beat_due;
	logic [SW-1:0]     wpos_next;
	logic [31:0]       age;

	assign quo_neg = -quo_q;
	assign avg_w   = neg_q ? signed'(quo_neg[7:0]) : signed'(quo_q[7:0]);
	assign trial   = {rem_q, quo_q[SUMW-1]};
	assign divisor = {1'b0, cur_cnt_q};
	assign age     = now_q - rd_seen_q;

	assign wpos_next = (cur_wpos_q == SW'(RSSI_WINDOW - 1)) ? '0 : cur_wpos_q + SW'(1);

	// Candidate rule: lower hop first, then relay, then strictly stronger average.
	assign eligible = (rd_hop_q != HOP_UNSYNC) && (rd_hop_q < hop_q);
	always_comb begin
		take = 1'b0;
		if (rd_hop_q < lead_hop_q) begin
			take = 1'b1;
		end else if (rd_hop_q == lead_hop_q) begin
			if (rd_relay_q && !lead_relay_q) begin
				take = 1'b1;
			end else if ((rd_relay_q == lead_relay_q) && (rd_avg_q > lead_rssi_q)) begin
				take = 1'b1;
			end
		end
	end

	assign ok1   = par_ok_q && present_q;
	assign drop1 = par_ok_q && !present_q;
	assign drop2 = ok1 && !gw_q && (unacked_q >= limit_q);
	assign ok2   = ok1 && !drop2;
	assign pick  = !gw_q && !ok2 && found_q;

	assign beat_due = par_ok_q && ((now_q - last_beat_q) >= interval_q);

	always_comb begin
		status              = '0;
		status.action       = act_q;
		status.self_hello   = (addr_q == my_addr_q);
		status.idx_end      = (idx_q == fill_q);
		status.match        = (rd_addr_q == addr_q);
		status.table_full   = (fill_q == CW'(MAX_NEIGHBORS));
		status.stale        = (age > timeout_q);
		status.keep_differs = (keep_q != idx_q);
		status.copy_last    = (slot_q == SW'(RSSI_WINDOW - 1));
		status.sum_last     = ((NW'(slot_q) + NW'(1)) == cur_cnt_q);
		status.div_last     = (div_cnt_q == DCW'(1));
		status.out_free     = !out_valid || !out_stall;
	end

	// Memory write selection.
	always_comb begin
		rec_we      = 1'b0;
		rec_wa      = idx_q[EW-1:0];
		rec_w_addr  = addr_q;
		rec_w_hop   = hop_in_q;
		rec_w_relay = relay_in_q;
		rec_w_cnt   = cur_cnt_q;
		rec_w_wpos  = cur_wpos_q;
		rec_w_avg   = avg_w;
		rec_w_seen  = now_q;
		win_we      = 1'b0;
		win_wa      = {idx_q[EW-1:0], cur_wpos_q};
		win_wd      = rssi_q;
		if (op == OP_HELLO_WRITE) begin
			rec_we = 1'b1;
		end
		if (op == OP_KEEP) begin
			rec_we      = 1'b1;
			rec_wa      = keep_q[EW-1:0];
			rec_w_addr  = rd_addr_q;
			rec_w_hop   = rd_hop_q;
			rec_w_relay = rd_relay_q;
			rec_w_cnt   = rd_cnt_q;
			rec_w_wpos  = rd_wpos_q;
			rec_w_avg   = rd_avg_q;
			rec_w_seen  = rd_seen_q;
		end
		if (op == OP_SAMPLE) begin
			win_we = 1'b1;
		end
		if (op == OP_COPY) begin
			win_we = 1'b1;
			win_wa = {keep_q[EW-1:0], slot_q};
			win_wd = win_rd_q;
		end
	end

	always_ff @(posedge clk) begin
		rd_addr_q  <= rec_addr_m[idx_q[EW-1:0]];
		rd_hop_q   <= rec_hop_m[idx_q[EW-1:0]];
		rd_relay_q <= rec_relay_m[idx_q[EW-1:0]];
		rd_cnt_q   <= rec_cnt_m[idx_q[EW-1:0]];
		rd_wpos_q  <= rec_wpos_m[idx_q[EW-1:0]];
		rd_avg_q   <= rec_avg_m[idx_q[EW-1:0]];
		rd_seen_q  <= rec_seen_m[idx_q[EW-1:0]];
		if (rec_we) begin
			rec_addr_m[rec_wa]  <= rec_w_addr;
			rec_hop_m[rec_wa]   <= rec_w_hop;
			rec_relay_m[rec_wa] <= rec_w_relay;
			rec_cnt_m[rec_wa]   <= rec_w_cnt;
			rec_wpos_m[rec_wa]  <= rec_w_wpos;
			rec_avg_m[rec_wa]   <= rec_w_avg;
			rec_seen_m[rec_wa]  <= rec_w_seen;
		end
	end

	// Window slots at or above the sample count are never summed, so a new
	// entry needs no clearing.
	always_ff @(posedge clk) begin
		win_rd_q <= win_m[{idx_q[EW-1:0], slot_q}];
		if (win_we) begin
			win_m[win_wa] <= win_wd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q        <= ACT_HELLO;
			now_q        <= '0;
			addr_q       <= '0;
			hop_in_q     <= '0;
			relay_in_q   <= 1'b0;
			rssi_q       <= '0;
			gw_q         <= 1'b0;
			my_addr_q    <= '0;
			timeout_q    <= 32'd10000;
			interval_q   <= 32'd5000;
			limit_q      <= 8'd3;
			fill_q       <= '0;
			par_addr_q   <= '0;
			par_ok_q     <= 1'b0;
			hop_q        <= HOP_UNSYNC;
			unacked_q    <= '0;
			last_beat_q  <= '0;
			seq_q        <= '0;
			idx_q        <= '0;
			keep_q       <= '0;
			slot_q       <= '0;
			cur_cnt_q    <= '0;
			cur_wpos_q   <= '0;
			sum_q        <= '0;
			rem_q        <= '0;
			quo_q        <= '0;
			neg_q        <= 1'b0;
			div_cnt_q    <= '0;
			found_q      <= 1'b0;
			lead_hop_q   <= HOP_UNSYNC;
			lead_relay_q <= 1'b0;
			lead_rssi_q  <= RSSI_FLOOR;
			lead_addr_q  <= '0;
			present_q    <= 1'b0;
			sel_q        <= 1'b0;
			drop_q       <= 1'b0;
			hbs_q        <= 1'b0;
			hbn_q        <= '0;
			hdrop_q      <= 1'b0;
		end else begin
			unique case (op)
				OP_NONE: begin
				end
				OP_LOAD: begin
					act_q        <= action_t'(action);
					now_q        <= now_ms;
					addr_q       <= sender_address;
					hop_in_q     <= sender_hop;
					relay_in_q   <= sender_relay;
					rssi_q       <= link_rssi;
					idx_q        <= '0;
					keep_q       <= '0;
					slot_q       <= '0;
					found_q      <= 1'b0;
					lead_hop_q   <= HOP_UNSYNC;
					lead_relay_q <= 1'b0;
					lead_rssi_q  <= RSSI_FLOOR;
					present_q    <= 1'b0;
					sel_q        <= 1'b0;
					drop_q       <= 1'b0;
					hbs_q        <= 1'b0;
					hbn_q        <= '0;
					hdrop_q      <= 1'b0;
				end
				OP_IDX_INC: idx_q <= idx_q + CW'(1);
				OP_FOUND: begin
					cur_cnt_q  <= rd_cnt_q;
					cur_wpos_q <= rd_wpos_q;
				end
				OP_CREATE: begin
					idx_q      <= fill_q;
					cur_cnt_q  <= '0;
					cur_wpos_q <= '0;
					fill_q     <= fill_q + CW'(1);
				end
				OP_HELLO_DROP: hdrop_q <= 1'b1;
				OP_SAMPLE: begin
					cur_wpos_q <= wpos_next;
					if (cur_cnt_q != NW'(RSSI_WINDOW)) begin
						cur_cnt_q <= cur_cnt_q + NW'(1);
					end
					slot_q <= '0;
					sum_q  <= '0;
				end
				OP_SUM_ACC: begin
					sum_q  <= sum_q + {{(SUMW - 8){win_rd_q[7]}}, win_rd_q};
					slot_q <= slot_q + SW'(1);
				end
				OP_DIV_START: begin
					neg_q     <= sum_q[SUMW-1];
					quo_q     <= sum_q[SUMW-1] ? -sum_q : sum_q;
					rem_q     <= '0;
					div_cnt_q <= DCW'(SUMW);
				end
				OP_DIV_STEP: begin
					if (trial >= divisor) begin
						rem_q <= NW'(trial - divisor);
						quo_q <= {quo_q[SUMW-2:0], 1'b1};
					end else begin
						rem_q <= trial[NW-1:0];
						quo_q <= {quo_q[SUMW-2:0], 1'b0};
					end
					div_cnt_q <= div_cnt_q - DCW'(1);
				end
				OP_HELLO_WRITE: begin
				end
				OP_KEEP: begin
					slot_q <= '0;
					if (rd_addr_q == par_addr_q) begin
						present_q <= 1'b1;
					end
					if (eligible && take) begin
						found_q      <= 1'b1;
						lead_hop_q   <= rd_hop_q;
						lead_relay_q <= rd_relay_q;
						lead_rssi_q  <= rd_avg_q;
						lead_addr_q  <= rd_addr_q;
					end
				end
				OP_COPY: slot_q <= slot_q + SW'(1);
				OP_ADVANCE: begin
					keep_q <= keep_q + CW'(1);
					idx_q  <= idx_q + CW'(1);
				end
				OP_TICK_FINAL: begin
					fill_q   <= keep_q;
					par_ok_q <= ok2 || pick;
					drop_q   <= drop1 || drop2;
					if (drop1 || drop2) begin
						unacked_q <= '0;
					end
					if (pick) begin
						par_addr_q <= lead_addr_q;
						hop_q      <= lead_hop_q + 8'd1;
						unacked_q  <= '0;
						sel_q      <= 1'b1;
					end
				end
				OP_BEAT: begin
					if (beat_due) begin
						last_beat_q <= now_q;
						hbs_q       <= 1'b1;
						hbn_q       <= seq_q;
						seq_q       <= seq_q + 32'd1;
						if (unacked_q != 8'hFF) begin
							unacked_q <= unacked_q + 8'd1;
						end
					end
				end
				OP_ACK: begin
					if (addr_q == par_addr_q) begin
						unacked_q <= '0;
					end
				end
				OP_EMIT: begin
				end
				default: begin
				end
			endcase

			if (cfg_write) begin
				unique case (cfg_index)
					CFG_GATEWAY: begin
						gw_q <= cfg_data[0];
						if (cfg_data[0]) begin
							hop_q      <= '0;
							par_ok_q   <= 1'b0;
							par_addr_q <= '0;
						end
					end
					CFG_MY_ADDR:   my_addr_q  <= cfg_data;
					CFG_TIMEOUT:   timeout_q  <= cfg_data[31:0];
					CFG_INTERVAL:  interval_q <= cfg_data[31:0];
					CFG_RETRY_LIM: limit_q    <= cfg_data[7:0];
					default: begin
					end
				endcase
			end
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (op == OP_EMIT) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (op == OP_EMIT) begin
			parent_valid     <= par_ok_q;
			parent_address   <= par_ok_q ? par_addr_q : '0;
			own_hop          <= hop_q;
			neighbor_total   <= fill_q;
			parent_selected  <= sel_q;
			parent_dropped   <= drop_q;
			heartbeat_send   <= hbs_q;
			heartbeat_number <= hbn_q;
			hello_dropped    <= hdrop_q;
		end
	end

endmodule

`default_nettype wire

// ----- hdl/mesh_neighbor_table_parent_select.sv -----
// ----------------------------------------------------------------------------
// mesh_neighbor_table_parent_select
// Mesh neighbor table with windowed RSSI averages and parent selection.
// ----------------------------------------------------------------------------
// Usage: one event beat enters on in_valid/in_stall (hello, process tick,
// heartbeat tick or heartbeat ack) and exactly one result beat leaves on
// out_valid/out_stall. Configuration is written through cfg_write,
// cfg_index and cfg_data while no event is in flight.
// Latency depends on the event. A hello searches the table entry by entry,
// sums the stored samples and runs SUMW (8 + bits of the sample count)
// divider steps; the serial divider and the single read port of the record
// memory set this. A process tick visits each entry, keeping or removing
// it, and copies all RSSI_WINDOW window slots of each entry moved down.
// One event is processed at a time; in_stall is high from acceptance until
// its result is loaded into the output register.
// Reset clears the table, the parent and the counters; hop count becomes 255.
// A stalled result holds in the output register; the next event can be taken
// and worked on meanwhile but its result waits until the register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module mesh_neighbor_table_parent_select import mntps_pkg::*; #(
	parameter int MAX_NEIGHBORS = 16,
	parameter int RSSI_WINDOW   = 8
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire logic [1:0]           action,
	input  wire logic [31:0]          now_ms,
	input  wire logic [47:0]          sender_address,
	input  wire logic [7:0]           sender_hop,
	input  wire logic                 sender_relay,
	input  wire logic signed [7:0]    link_rssi,
	input  wire logic                 cfg_write,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [47:0]          cfg_data,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output logic                      parent_valid,
	output logic [47:0]               parent_address,
	output logic [7:0]                own_hop,
	output logic [$clog2(MAX_NEIGHBORS + 1)-1:0] neighbor_total,
	output logic                      parent_selected,
	output logic                      parent_dropped,
	output logic                      heartbeat_send,
	output logic [31:0]               heartbeat_number,
	output logic                      hello_dropped
);

	dp_op_t     op;
	dp_status_t status;

	mntps_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.status   (status),
		.op       (op)
	);

	mntps_datapath #(
		.MAX_NEIGHBORS (MAX_NEIGHBORS),
		.RSSI_WINDOW   (RSSI_WINDOW)
	) u_datapath (
		.clk              (clk),
		.arst_n           (arst_n),
		.op               (op),
		.status           (status),
		.cfg_write        (cfg_write),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.action           (action),
		.now_ms           (now_ms),
		.sender_address   (sender_address),
		.sender_hop       (sender_hop),
		.sender_relay     (sender_relay),
		.link_rssi        (link_rssi),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.parent_valid     (parent_valid),
		.parent_address   (parent_address),
		.own_hop          (own_hop),
		.neighbor_total   (neighbor_total),
		.parent_selected  (parent_selected),
		.parent_dropped   (parent_dropped),
		.heartbeat_send   (heartbeat_send),
		.heartbeat_number (heartbeat_number),
		.hello_dropped    (hello_dropped)
	);

endmodule

`default_nettype wire

// ----- hdl/mntps_checker.sv -----
// ----------------------------------------------------------------------------
// mntps_checker
// Port-level checks of the neighbor table block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module mntps_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_stall,
	input wire logic        out_valid,
	input wire logic        out_stall,
	input wire logic        parent_valid,
	input wire logic [47:0] parent_address,
	input wire logic        parent_selected,
	input wire logic        heartbeat_send,
	input wire logic [31:0] heartbeat_number
);

	// A stalled result beat stays offered.
	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid)

	// One event at a time: the block is busy right after taking a beat.
	`ASSERT_NEXT(a_busy_after_accept, clk, arst_n, in_valid && !in_stall, in_stall)

	// Without a parent the reported address reads as zero.
	`ASSERT_IMPLY(a_addr_zero, clk, arst_n, out_valid && !parent_valid,
		parent_address == 48'd0)

	// A parent chosen during the event is held when the result leaves.
	`ASSERT_IMPLY(a_sel_valid, clk, arst_n, out_valid && parent_selected, parent_valid)

	// The sequence number is only reported with a heartbeat.
	`ASSERT_IMPLY(a_beat_num, clk, arst_n, out_valid && !heartbeat_send,
		heartbeat_number == 32'd0)

endmodule

bind mesh_neighbor_table_parent_select mntps_checker u_checker (.*);

`default_nettype wire
